// File: src/coin_sum_combination_finder_top_assert.svh
// Assertion macros for the top level of the coin sum combination finder.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef COIN_SUM_COMBINATION_FINDER_TOP_ASSERT_SVH
`define COIN_SUM_COMBINATION_FINDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CSF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// Next-cycle implication
`define CSF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define CSF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CSF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/csf_pkg.sv
package csf_pkg;

   localparam int VAL_W          = 6;
   localparam int MODE_W         = 2;
   localparam int MAX_PARTS_DEF  = 8;
   localparam int MAX_TARGET_DEF = 63;

   // Transaction modes
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SOLVE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_CHECK,
      ST_TRACE_RD,
      ST_TRACE_WR,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic accept;
      logic load;
      logic fill_step;
      logic trace_rd;
      logic trace_wr;
      logic emit_rd;
      logic emit_out;
      logic spec_out;
      logic spec_found;
   } ctrl_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic fill_done;
      logic target_reach;
      logic trace_end;
      logic emit_end;
   } stat_type;

endpackage

// File: src/csf_ctrl.sv
module csf_ctrl #(
   parameter int MAX_TARGET = csf_pkg::MAX_TARGET_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [csf_pkg::MODE_W-1:0]   req_mode,
   input  logic [csf_pkg::VAL_W-1:0]    req_value,
   input  csf_pkg::stat_type            stat,
   output csf_pkg::ctrl_type            cmd,
   output logic                         busy
);
   import csf_pkg::*;

   state_type state_ff, state_in;
   logic      accept;
   logic      solve_acc;
   logic      tgt_zero;
   logic      tgt_over;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign solve_acc = accept && (req_mode == MODE_SOLVE);
   assign tgt_zero  = (req_value == '0);
   assign tgt_over  = (req_value > VAL_W'(MAX_TARGET));

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick the next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (solve_acc && !tgt_zero && !tgt_over) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (stat.fill_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.target_reach ? ST_TRACE_RD : ST_IDLE;
         end
         ST_TRACE_RD: begin
            state_in = ST_TRACE_WR;
         end
         ST_TRACE_WR: begin
            state_in = stat.trace_end ? ST_EMIT_RD : ST_TRACE_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            state_in = stat.emit_end ? ST_IDLE : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive the datapath commands
   always_comb begin
      cmd        = '0;
      cmd.accept = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (solve_acc) begin
               if (tgt_zero) begin
                  cmd.spec_out   = 1'b1;
                  cmd.spec_found = 1'b1;
               end else if (tgt_over) begin
                  cmd.spec_out = 1'b1;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
         end
         ST_CHECK: begin
            cmd.spec_out = !stat.target_reach;
         end
         ST_TRACE_RD: begin
            cmd.trace_rd = 1'b1;
         end
         ST_TRACE_WR: begin
            cmd.trace_wr = 1'b1;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
         end
         ST_EMIT_OUT: begin
            cmd.emit_out = 1'b1;
         end
         default: begin
            cmd.accept = accept;
         end
      endcase
   end

endmodule

// File: src/csf_dp.sv
module csf_dp #(
   parameter int MAX_PARTS  = csf_pkg::MAX_PARTS_DEF,
   parameter int MAX_TARGET = csf_pkg::MAX_TARGET_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [csf_pkg::MODE_W-1:0]   req_mode,
   input  logic [csf_pkg::VAL_W-1:0]    req_value,
   input  csf_pkg::ctrl_type            cmd,
   output csf_pkg::stat_type            stat,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic                         rsp_has_part,
   output logic [csf_pkg::VAL_W-1:0]    rsp_part,
   output logic                         rsp_last
);
   import csf_pkg::*;

   localparam int TBL_DEPTH = MAX_TARGET + 1;
   localparam int TIDX_W    = $clog2(TBL_DEPTH);
   localparam int PATH_AW   = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
   localparam int CNT_W     = $clog2(MAX_PARTS + 1);
   localparam int PIDX_W    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int SUM_W     = VAL_W + 1;

   // Part list and its fill count
   logic [VAL_W-1:0]     part_list_ff [MAX_PARTS];
   logic [CNT_W-1:0]     part_count_ff, part_count_in;

   // Sweep and trace state
   logic [TBL_DEPTH-1:0] reach_ff, reach_in;
   logic [TIDX_W-1:0]    target_ff;
   logic [TIDX_W-1:0]    i_ff;
   logic [PIDX_W-1:0]    n_ff;
   logic [TIDX_W-1:0]    s_ff;
   logic [TIDX_W-1:0]    k_ff;
   logic [TIDX_W-1:0]    k_dec;

   // Table of last part used and trace-back store
   logic [VAL_W-1:0]     lpu_mem  [TBL_DEPTH];
   logic [VAL_W-1:0]     lpu_rd_ff;
   logic [VAL_W-1:0]     path_mem [MAX_TARGET];
   logic [VAL_W-1:0]     path_rd_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic                 rsp_has_part_ff;
   logic [VAL_W-1:0]     rsp_part_ff;
   logic                 rsp_last_ff;

   logic                 append_ok;
   logic                 reach_i;
   logic [VAL_W-1:0]     part_n;
   logic                 have_parts;
   logic                 n_last;
   logic [SUM_W-1:0]     sum;
   logic                 do_mark;
   logic                 advance_i;

   // Decode list edits
   assign append_ok = cmd.accept && (req_mode == MODE_APPEND) && (req_value != '0)
                      && (part_count_ff < CNT_W'(MAX_PARTS));

   always_comb begin
      part_count_in = part_count_ff;
      if (cmd.accept && (req_mode == MODE_CLEAR)) begin
         part_count_in = '0;
      end else if (append_ok) begin
         part_count_in = part_count_ff + CNT_W'(1);
      end
   end

   // Shared step: add one part to the current sum and compare with the target
   assign reach_i    = reach_ff[i_ff];
   assign part_n     = part_list_ff[n_ff];
   assign have_parts = (part_count_ff != '0);
   assign n_last     = ((CNT_W'(n_ff) + CNT_W'(1)) == part_count_ff);
   assign sum        = SUM_W'(i_ff) + SUM_W'(part_n);
   assign do_mark    = cmd.fill_step && have_parts && reach_i && (sum <= SUM_W'(target_ff));
   assign advance_i  = !have_parts || !reach_i || n_last;
   assign k_dec      = k_ff - TIDX_W'(1);

   assign stat.fill_done    = advance_i && (i_ff == target_ff);
   assign stat.target_reach = reach_ff[target_ff];
   assign stat.trace_end    = (VAL_W'(s_ff) == lpu_rd_ff);
   assign stat.emit_end     = (k_ff == '0);

   // Clear the reachable bits but sum zero on a solve, mark them during the sweep
   always_comb begin
      reach_in = reach_ff;
      if (cmd.load) begin
         reach_in = TBL_DEPTH'(1);
      end else if (do_mark) begin
         reach_in[sum[TIDX_W-1:0]] = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         part_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         i_ff          <= '0;
         n_ff          <= '0;
         s_ff          <= '0;
         k_ff          <= '0;
      end else begin
         part_count_ff <= part_count_in;
         rsp_valid_ff  <= cmd.spec_out || cmd.emit_out;
         if (cmd.load) begin
            i_ff <= '0;
            n_ff <= '0;
            s_ff <= req_value[TIDX_W-1:0];
            k_ff <= '0;
         end else if (cmd.fill_step) begin
            if (advance_i) begin
               n_ff <= '0;
               i_ff <= i_ff + TIDX_W'(1);
            end else begin
               n_ff <= n_ff + PIDX_W'(1);
            end
         end else if (cmd.trace_wr) begin
            s_ff <= s_ff - TIDX_W'(lpu_rd_ff);
            k_ff <= k_ff + TIDX_W'(1);
         end else if (cmd.emit_rd) begin
            k_ff <= k_dec;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      reach_ff <= reach_in;
      if (append_ok) begin
         part_list_ff[part_count_ff[PIDX_W-1:0]] <= req_value;
      end
      if (cmd.load) begin
         target_ff <= req_value[TIDX_W-1:0];
      end
      if (cmd.spec_out) begin
         rsp_found_ff    <= cmd.spec_found;
         rsp_has_part_ff <= 1'b0;
         rsp_part_ff     <= '0;
         rsp_last_ff     <= 1'b1;
      end else if (cmd.emit_out) begin
         rsp_found_ff    <= 1'b1;
         rsp_has_part_ff <= 1'b1;
         rsp_part_ff     <= path_rd_ff;
         rsp_last_ff     <= stat.emit_end;
      end
   end

   // Record the last part used and read it back during the trace
   always_ff @(posedge clock) begin
      if (do_mark) begin
         lpu_mem[sum[TIDX_W-1:0]] <= part_n;
      end
      if (cmd.trace_rd) begin
         lpu_rd_ff <= lpu_mem[s_ff];
      end
   end

   // Push traced parts, pop them in build order
   always_ff @(posedge clock) begin
      if (cmd.trace_wr) begin
         path_mem[k_ff[PATH_AW-1:0]] <= lpu_rd_ff;
      end
      if (cmd.emit_rd) begin
         path_rd_ff <= path_mem[k_dec[PATH_AW-1:0]];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_has_part = rsp_has_part_ff;
   assign rsp_part     = rsp_part_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: src/coin_sum_combination_finder_top.sv
// Coin sum combination finder.
// Request channel: req_mode and req_value are taken at a rising edge where
// start is high and busy is low. Mode clear empties the part list, mode append
// adds a nonzero part while the list has room, mode solve searches for a target.
// Clear and append give no result; busy stays low.
// A solve for target zero, or above MAX_TARGET, gives one result the next cycle.
// Otherwise busy rises and the block sweeps sums 0..target, stepping through
// the listed parts for each reachable sum and skipping an unreachable one,
// through a single add-and-compare unit; a check state then tests the target.
// A found target is traced back, one read of the table memory per part, and
// then emitted, one read of the trace store per part.
// Response channel: rsp_valid strobes for one cycle per result, with
// rsp_found, rsp_has_part, rsp_part and rsp_last; the last result is
// flagged. The receiver cannot stall the block.
// Reset empties the part list and returns the sequencer to idle; no clearing
// pass is needed.
`include "coin_sum_combination_finder_top_assert.svh"

module coin_sum_combination_finder_top #(
   parameter int MAX_PARTS  = csf_pkg::MAX_PARTS_DEF,
   parameter int MAX_TARGET = csf_pkg::MAX_TARGET_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [csf_pkg::MODE_W-1:0]   req_mode,
   input  logic [csf_pkg::VAL_W-1:0]    req_value,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic                         rsp_has_part,
   output logic [csf_pkg::VAL_W-1:0]    rsp_part,
   output logic                         rsp_last
);
   import csf_pkg::*;

   ctrl_type cmd;
   stat_type stat;

   // Sequencer
   csf_ctrl #(
      .MAX_TARGET (MAX_TARGET)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .req_value (req_value),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   // Tables, shared step unit and result register
   csf_dp #(
      .MAX_PARTS  (MAX_PARTS),
      .MAX_TARGET (MAX_TARGET)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_has_part (rsp_has_part),
      .rsp_part     (rsp_part),
      .rsp_last     (rsp_last)
   );

   // A part is only carried by a found result
   `CSF_ASSERT_IMP(a_part_implies_found, clock, reset, rsp_valid && rsp_has_part, rsp_found)
   // A not-found result stands alone and carries no part
   `CSF_ASSERT_IMP(a_notfound_alone, clock, reset, rsp_valid && !rsp_found, rsp_last && !rsp_has_part && (rsp_part == '0))
   // Target zero answers at once with an empty found result
   `CSF_ASSERT_NXT(a_zero_target, clock, reset, start && !busy && (req_mode == MODE_SOLVE) && (req_value == '0), rsp_valid && rsp_found && rsp_last && !rsp_has_part)
   // A solve within range starts the sweep
   `CSF_ASSERT_NXT(a_solve_busy, clock, reset, start && !busy && (req_mode == MODE_SOLVE) && (req_value != '0) && (req_value <= VAL_W'(MAX_TARGET)), busy && !rsp_valid)

endmodule
